[design/rc5_pkg.sv]
`default_nettype none
package rc5_pkg;

  localparam int ROUNDS     = 16;
  localparam int KEY_BYTES  = 16;
  localparam int RK_COUNT   = 2 * (ROUNDS + 1);
  localparam int KEY_WORDS  = (KEY_BYTES + 3) / 4;
  localparam int RK_AW      = $clog2(RK_COUNT);
  localparam int RND_W      = $clog2(ROUNDS + 1);
  localparam int MIX_TOTAL  = 3 * ((RK_COUNT > KEY_WORDS) ? RK_COUNT : KEY_WORDS);
  localparam int MIX_W      = $clog2(MIX_TOTAL);
  localparam int WORD_IDX_W = 2;
  localparam int CFG_AW     = 2;

  localparam logic [31:0] MAGIC_P  = 32'hb7e15163;
  localparam logic [31:0] MAGIC_Q  = 32'h9e3779b9;
  localparam logic [63:0] IV_RESET = 64'h0101010101010101;

  // opcodes
  localparam logic [1:0] OP_EXPAND  = 2'd0;
  localparam logic [1:0] OP_ENCRYPT = 2'd1;
  localparam logic [1:0] OP_DECRYPT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_KEY_LOW     = 2'd0;
  localparam logic [CFG_AW-1:0] REG_KEY_HIGH    = 2'd1;
  localparam logic [CFG_AW-1:0] REG_INIT_VECTOR = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_KEY_INIT,
    S_MIX_A,
    S_MIX_B,
    S_ENC_WHITE,
    S_ENC_ROUND,
    S_DEC_ROUND,
    S_DEC_WHITE,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    OUT_ENC,
    OUT_DEC,
    OUT_ZERO,
    OUT_ERR
  } out_kind_t;

  typedef struct packed {
    logic                  load_key;
    logic                  load_enc;
    logic                  load_dec;
    logic                  init_wr;
    logic                  mix_a;
    logic                  mix_b;
    logic                  enc_white;
    logic                  enc_round;
    logic                  dec_round;
    logic                  dec_white;
    logic                  out_load;
    out_kind_t             out_kind;
    logic [RK_AW-1:0]      raddr0;
    logic [RK_AW-1:0]      raddr1;
    logic [RK_AW-1:0]      kaddr;
    logic [WORD_IDX_W-1:0] widx;
  } dp_cmd_t;

endpackage
`default_nettype wire

[design/rc5_datapath.sv]
`default_nettype none
module rc5_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [rc5_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [63:0]                cfg_data,
  input  wire logic [63:0]                in_block,
  input  wire logic                       in_first,
  input  wire rc5_pkg::dp_cmd_t           cmd,
  output logic [63:0]                     out_block,
  output logic                            out_status
);
  import rc5_pkg::*;

  function automatic logic [31:0] rol32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] t;
    t = {v, v} << s;
    return t[63:32];
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] t;
    t = {v, v} >> s;
    return t[31:0];
  endfunction

  function automatic logic [127:0] key_bytes(input logic [63:0] lo, input logic [63:0] hi);
    logic [127:0] src;
    logic [127:0] w;
    src = {hi, lo};
    w   = '0;
    for (int k = 0; k < 16; k++) begin
      if (k < KEY_BYTES) w[k*8 +: 8] = src[k*8 +: 8];
    end
    return w;
  endfunction

  logic [63:0] key_low, key_high, init_vector;
  logic [63:0] chain;
  logic [63:0] xmask;
  logic [31:0] a, b;
  logic [31:0] init_val;
  logic [31:0] lw [4];
  logic [31:0] rk_mem [RK_COUNT];
  logic [31:0] rd0, rd1;

  logic [63:0]  chain_eff;
  logic [127:0] kw;
  logic [31:0]  ea, eb, da, db, ma, mb, ab_sum;

  assign chain_eff = in_first ? init_vector : chain;
  assign kw        = key_bytes(key_low, key_high);

  always_comb begin
    ea     = rol32(a ^ b, b[4:0]) + rd0;
    eb     = rol32(ea ^ b, ea[4:0]) + rd1;
    db     = ror32(b - rd1, a[4:0]) ^ a;
    da     = ror32(a - rd0, db[4:0]) ^ db;
    ma     = rol32(rd0 + a + b, 5'd3);
    ab_sum = a + b;
    mb     = rol32(lw[cmd.widx] + ab_sum, ab_sum[4:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low     <= '0;
      key_high    <= '0;
      init_vector <= IV_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_KEY_LOW:     key_low     <= cfg_data;
        REG_KEY_HIGH:    key_high    <= cfg_data;
        REG_INIT_VECTOR: init_vector <= cfg_data;
        default: ;
      endcase
    end
  end

  // round key store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.init_wr) begin
      rk_mem[cmd.kaddr] <= init_val;
    end else if (cmd.mix_a) begin
      rk_mem[cmd.kaddr] <= ma;
    end
    rd0 <= rk_mem[cmd.raddr0];
    rd1 <= rk_mem[cmd.raddr1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= '0;
    end else if (cmd.load_dec) begin
      chain <= in_block;
    end else if (cmd.out_load && cmd.out_kind == OUT_ENC) begin
      chain <= {b, a};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      for (int k = 0; k < 4; k++) lw[k] <= kw[k*32 +: 32];
      a        <= '0;
      b        <= '0;
      init_val <= MAGIC_P;
    end else if (cmd.init_wr) begin
      init_val <= init_val + MAGIC_Q;
    end else if (cmd.mix_a) begin
      a <= ma;
    end else if (cmd.mix_b) begin
      b            <= mb;
      lw[cmd.widx] <= mb;
    end else if (cmd.load_enc) begin
      {b, a} <= in_block ^ chain_eff;
    end else if (cmd.load_dec) begin
      {b, a} <= in_block;
      xmask  <= chain_eff;
    end else if (cmd.enc_white) begin
      a <= a + rd0;
      b <= b + rd1;
    end else if (cmd.enc_round) begin
      a <= ea;
      b <= eb;
    end else if (cmd.dec_round) begin
      a <= da;
      b <= db;
    end else if (cmd.dec_white) begin
      a <= a - rd0;
      b <= b - rd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_kind)
        OUT_ENC: begin
          out_block  <= {b, a};
          out_status <= 1'b0;
        end
        OUT_DEC: begin
          out_block  <= {b, a} ^ xmask;
          out_status <= 1'b0;
        end
        OUT_ERR: begin
          out_block  <= '0;
          out_status <= 1'b1;
        end
        default: begin
          out_block  <= '0;
          out_status <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[design/rc5_control.sv]
`default_nettype none
module rc5_control (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  output logic             out_valid,
  input  wire logic        out_ready,
  output rc5_pkg::dp_cmd_t cmd
);
  import rc5_pkg::*;

  state_t                state, state_next;
  out_kind_t             kind;
  logic [RK_AW-1:0]      idx;
  logic [WORD_IDX_W-1:0] widx;
  logic [MIX_W-1:0]      mix_cnt;
  logic [RND_W-1:0]      rnd;
  logic                  key_ready;

  logic                  accept;
  logic                  idx_last, mix_last, rnd_last, out_free;
  logic [RK_AW-1:0]      idx_wrap;
  logic [WORD_IDX_W-1:0] widx_wrap;
  logic [RK_AW-1:0]      base_next, base_prev;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign idx_last  = (idx == RK_AW'(RK_COUNT - 1));
  assign idx_wrap  = idx_last ? '0 : idx + 1'b1;
  assign widx_wrap = (widx == WORD_IDX_W'(KEY_WORDS - 1)) ? '0 : widx + 1'b1;
  assign mix_last  = (mix_cnt == MIX_W'(MIX_TOTAL - 1));
  assign rnd_last  = (rnd == RND_W'(ROUNDS));
  assign out_free  = !out_valid || out_ready;
  assign base_next = RK_AW'({rnd, 1'b0}) + RK_AW'(2);
  assign base_prev = RK_AW'({rnd, 1'b0}) - RK_AW'(2);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_EXPAND) state_next = S_KEY_INIT;
          else if (in_op == OP_ENCRYPT && key_ready) state_next = S_ENC_WHITE;
          else if (in_op == OP_DECRYPT && key_ready) state_next = S_DEC_ROUND;
          else state_next = S_FINISH;
        end
      end
      S_KEY_INIT:  if (idx_last) state_next = S_MIX_A;
      S_MIX_A:     state_next = S_MIX_B;
      S_MIX_B:     state_next = mix_last ? S_FINISH : S_MIX_A;
      S_ENC_WHITE: state_next = S_ENC_ROUND;
      S_ENC_ROUND: if (rnd_last) state_next = S_FINISH;
      S_DEC_ROUND: if (rnd == RND_W'(1)) state_next = S_DEC_WHITE;
      S_DEC_WHITE: state_next = S_FINISH;
      S_FINISH:    if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.out_kind = kind;
    cmd.kaddr    = idx;
    cmd.widx     = widx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load_key = (in_op == OP_EXPAND);
          cmd.load_enc = (in_op == OP_ENCRYPT) && key_ready;
          cmd.load_dec = (in_op == OP_DECRYPT) && key_ready;
        end
        if (in_op == OP_DECRYPT) begin
          cmd.raddr0 = RK_AW'(RK_COUNT - 2);
          cmd.raddr1 = RK_AW'(RK_COUNT - 1);
        end else begin
          cmd.raddr0 = RK_AW'(0);
          cmd.raddr1 = RK_AW'(1);
        end
      end
      S_KEY_INIT: cmd.init_wr = 1'b1;
      S_MIX_A:    cmd.mix_a   = 1'b1;
      S_MIX_B: begin
        cmd.mix_b  = 1'b1;
        cmd.raddr0 = idx_wrap;
      end
      S_ENC_WHITE: begin
        cmd.enc_white = 1'b1;
        cmd.raddr0    = RK_AW'(2);
        cmd.raddr1    = RK_AW'(3);
      end
      S_ENC_ROUND: begin
        cmd.enc_round = 1'b1;
        if (!rnd_last) begin
          cmd.raddr0 = base_next;
          cmd.raddr1 = base_next + 1'b1;
        end
      end
      S_DEC_ROUND: begin
        cmd.dec_round = 1'b1;
        cmd.raddr0    = base_prev;
        cmd.raddr1    = base_prev + 1'b1;
      end
      S_DEC_WHITE: cmd.dec_white = 1'b1;
      S_FINISH:    cmd.out_load  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      key_ready <= 1'b0;
      out_valid <= 1'b0;
      kind      <= OUT_ZERO;
      idx       <= '0;
      widx      <= '0;
      mix_cnt   <= '0;
      rnd       <= '0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            idx <= '0;
            rnd <= RND_W'(ROUNDS);
            if (in_op == OP_EXPAND) kind <= OUT_ZERO;
            else if (in_op == OP_ENCRYPT) kind <= key_ready ? OUT_ENC : OUT_ERR;
            else if (in_op == OP_DECRYPT) kind <= key_ready ? OUT_DEC : OUT_ERR;
            else kind <= OUT_ZERO;
          end
        end
        S_KEY_INIT: begin
          idx <= idx_wrap;
          if (idx_last) begin
            widx    <= '0;
            mix_cnt <= '0;
          end
        end
        S_MIX_B: begin
          idx     <= idx_wrap;
          widx    <= widx_wrap;
          mix_cnt <= mix_cnt + 1'b1;
          if (mix_last) key_ready <= 1'b1;
        end
        S_ENC_WHITE: rnd <= RND_W'(1);
        S_ENC_ROUND: if (!rnd_last) rnd <= rnd + 1'b1;
        S_DEC_ROUND: rnd <= rnd - 1'b1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[design/rc5_cbc_cipher.sv]
`default_nettype none
// Channel   Direction  Contents
// s_*       in         tuser: opcode[1:0], first_block[2]; tdata: data_block[63:0]
// m_*       out        tuser: status[0]; tdata: result_block[63:0]
// cfg_*     in         write port: key_low (0), key_high (1), init_vector (2)
//
// Encrypt and decrypt items: one RC5 round per cycle, with both round keys read from the
// dual read port key store; a new item is accepted only once the last one has finished. Key
// expansion writes the 2*(ROUNDS+1) initial round keys, then runs 6*(ROUNDS+1) mix steps,
// each through the MIX_A and MIX_B states, on the single write port. Error and unused
// items go straight to the finish state. One item in flight; the output register holds a
// result while the next item runs, which then waits until it is taken. Reset is synchronous.
module rc5_cbc_cipher (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [63:0]                s_tdata,  // data_block[63:0]
  input  wire logic [2:0]                 s_tuser,  // opcode[1:0], first_block[2]
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [63:0]                     m_tdata,  // result_block[63:0]
  output logic [0:0]                      m_tuser,  // status[0]
  input  wire logic                       cfg_we,
  input  wire logic [rc5_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [63:0]                cfg_data
);
  import rc5_pkg::*;

  dp_cmd_t cmd;

  rc5_control u_control (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser[1:0]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  rc5_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_block   (s_tdata),
    .in_first   (s_tuser[2]),
    .cmd        (cmd),
    .out_block  (m_tdata),
    .out_status (m_tuser[0])
  );

endmodule
`default_nettype wire
